### sv/imusfp_pkg.sv
// ----------------------------------------------------------------------------
// imusfp_pkg
// Shared codes and scaling constants for the imu serial frame parser.
// ----------------------------------------------------------------------------
package imusfp_pkg;

    // frame layout
    localparam logic [7:0] HEADER_BYTE = 8'h55;
    localparam logic [7:0] TYPE_ACCEL  = 8'h51;
    localparam logic [7:0] TYPE_RATE   = 8'h52;
    localparam logic [7:0] TYPE_ANGLE  = 8'h53;
    localparam int         FRAME_LEN   = 11;
    localparam int         COUNT_W     = 4;
    localparam int         PAYLOAD_LEN = 8;
    localparam int         NUM_AXES    = 3;

    // field widths
    localparam int RAW_W   = 16;
    localparam int AXIS_W  = 28;
    localparam int TEMP_W  = 25;
    localparam int TDATA_W = 112;

    // angle: 2*pi with 44 fraction bits, split at bit 24 for two small products
    localparam int                 PI_SPLIT   = 24;
    localparam int                 PI_FRAC    = 44;
    localparam logic signed [23:0] TWO_PI_HI  = 24'sh6487ED;
    localparam logic signed [24:0] TWO_PI_LO  = 25'sh05110B4;
    localparam int                 PI_HI_W    = RAW_W + 24;
    localparam int                 PI_LO_W    = RAW_W + 25;

    // angular rate: raw * 2000 / 32768 in q16
    localparam logic signed [12:0] RATE_SCALE = 13'sd4000;
    // acceleration: raw * 16 / 32768 in q16
    localparam int                 ACCEL_SHIFT = 5;

    // temperature: floor((raw * 65536 + 807731200) / 340)
    //   = floor((16384 * (raw + 32768) + 53) / 85) - 3940449
    // the divide by 85 is a multiply by ceil(2^37 / 85), exact below 2^30
    localparam int                 TNUM_W     = 30;
    localparam logic [TNUM_W-1:0]  TNUM_BIAS  = 30'd53;
    localparam logic [30:0]        RECIP_85   = 31'd1616928865;
    localparam int                 RECIP_SH   = 37;
    localparam int                 TPROD_W    = TNUM_W + 31;
    localparam logic signed [TEMP_W-1:0] TEMP_OFFSET = 25'sd3940449;

    // result kinds
    typedef enum logic [1:0] {
        KIND_ACCEL = 2'd0,
        KIND_RATE  = 2'd1,
        KIND_ANGLE = 2'd2
    } frame_kind_t;

endpackage

### sv/imu_serial_frame_parser.sv
// ----------------------------------------------------------------------------
// imu_serial_frame_parser
// A result is registered in the product stage and then in the output register before m_tvalid offers it.
// Throughput: one received byte per cycle unless the output side stalls; at most one result per 11 bytes.
// The rate is set by the product register stage and the output register,
// which both advance every cycle unless the output side stalls.
// Reset (aresetn low, synchronous): byte counter to hunting, pipeline empty.
// Assembles 11-byte sensor frames and emits scaled q16 axis and temperature.
// ----------------------------------------------------------------------------
module imu_serial_frame_parser (
    input  logic                          aclk,
    input  logic                          aresetn,
    // slave side: one received serial byte per item
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] rx_byte
    // master side: one decoded frame per item
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [imusfp_pkg::TDATA_W-1:0] m_tdata,  // [27:0] axis_x, [55:28] axis_y,
                                                     // [83:56] axis_z, [108:84] temperature
    output logic [1:0]                    m_tuser    // [1:0] frame_kind
);
    import imusfp_pkg::*;

    // frame assembly state
    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [7:0]         type_byte_reg;
    logic [7:0]         payload_reg [PAYLOAD_LEN];

    // product stage
    logic                          b_valid_reg, b_valid_next;
    frame_kind_t                   b_kind_reg;
    logic signed [RAW_W-1:0]       b_word_reg  [NUM_AXES];
    logic signed [PI_HI_W-1:0]     b_hi_reg    [NUM_AXES];
    logic signed [PI_LO_W-1:0]     b_lo_reg    [NUM_AXES];
    logic signed [AXIS_W-1:0]      b_rate_reg  [NUM_AXES];
    logic [TPROD_W-1:0]            b_tprod_reg;

    // output register
    logic                          m_valid_reg, m_valid_next;
    frame_kind_t                   m_kind_reg;
    logic signed [AXIS_W-1:0]      m_axis_reg  [NUM_AXES];
    logic signed [TEMP_W-1:0]      m_temp_reg;

    logic                          in_accept;
    logic                          out_ready;
    logic                          b_ready;
    logic                          frame_done;
    logic                          kind_valid;
    frame_kind_t                   kind_dec;
    logic [2:0]                    store_idx;

    logic signed [RAW_W-1:0]       word     [PAYLOAD_LEN/2];
    logic signed [PI_HI_W-1:0]     hi_prod  [NUM_AXES];
    logic signed [PI_LO_W-1:0]     lo_prod  [NUM_AXES];
    logic signed [AXIS_W-1:0]      rate_prod[NUM_AXES];
    logic [TNUM_W-1:0]             tnum;
    logic [TPROD_W-1:0]            tprod;

    logic signed [63:0]            angle_sum[NUM_AXES];
    logic signed [AXIS_W-1:0]      axis_val [NUM_AXES];
    logic signed [TEMP_W-1:0]      temp_val;

    // handshake chain
    assign out_ready = !m_valid_reg || m_tready;
    assign b_ready   = !b_valid_reg || out_ready;
    assign s_tready  = b_ready;
    assign in_accept = s_tvalid && s_tready;

    // type byte decode
    always_comb begin
        kind_valid = 1'b1;
        kind_dec   = KIND_ACCEL;
        case (type_byte_reg)
            TYPE_ACCEL: kind_dec = KIND_ACCEL;
            TYPE_RATE:  kind_dec = KIND_RATE;
            TYPE_ANGLE: kind_dec = KIND_ANGLE;
            default:    kind_valid = 1'b0;
        endcase
    end

    assign frame_done = in_accept && (byte_count_reg == COUNT_W'(FRAME_LEN - 1));
    assign store_idx  = 3'(byte_count_reg - COUNT_W'(2));

    // byte counter
    always_comb begin
        byte_count_next = byte_count_reg;
        if (in_accept) begin
            if (byte_count_reg == '0) begin
                if (s_tdata == HEADER_BYTE) begin
                    byte_count_next = COUNT_W'(1);
                end
            end else if (byte_count_reg < COUNT_W'(FRAME_LEN - 1)) begin
                byte_count_next = byte_count_reg + COUNT_W'(1);
            end else begin
                byte_count_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
        end else begin
            byte_count_reg <= byte_count_next;
        end
    end

    // type and payload capture
    always_ff @(posedge aclk) begin
        if (in_accept && byte_count_reg == COUNT_W'(1)) begin
            type_byte_reg <= s_tdata;
        end
        if (in_accept && byte_count_reg >= COUNT_W'(2)
                && byte_count_reg <= COUNT_W'(FRAME_LEN - 2)) begin
            payload_reg[store_idx] <= s_tdata;
        end
    end

    // little-endian words from the payload
    always_comb begin
        for (int k = 0; k < PAYLOAD_LEN / 2; k++) begin
            word[k] = signed'({payload_reg[2*k+1], payload_reg[2*k]});
        end
    end

    // per-axis products and temperature reciprocal product
    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            hi_prod[i]   = PI_HI_W'(word[i]) * PI_HI_W'(TWO_PI_HI);
            lo_prod[i]   = PI_LO_W'(word[i]) * PI_LO_W'(TWO_PI_LO);
            rate_prod[i] = AXIS_W'(word[i]) * AXIS_W'(RATE_SCALE);
        end
        tnum  = {~word[3][RAW_W-1], word[3][RAW_W-2:0], 14'b0} + TNUM_BIAS;
        tprod = TPROD_W'(tnum) * TPROD_W'(RECIP_85);
    end

    // product stage registers
    assign b_valid_next = frame_done ? kind_valid : (out_ready ? 1'b0 : b_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (frame_done) begin
            b_kind_reg  <= kind_dec;
            b_tprod_reg <= tprod;
            for (int i = 0; i < NUM_AXES; i++) begin
                b_word_reg[i] <= word[i];
                b_hi_reg[i]   <= hi_prod[i];
                b_lo_reg[i]   <= lo_prod[i];
                b_rate_reg[i] <= rate_prod[i];
            end
        end
    end

    // final scaling per kind
    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            angle_sum[i] = (64'(b_hi_reg[i]) <<< PI_SPLIT) + 64'(b_lo_reg[i]);
            case (b_kind_reg)
                KIND_ACCEL: axis_val[i] = AXIS_W'(b_word_reg[i]) <<< ACCEL_SHIFT;
                KIND_RATE:  axis_val[i] = b_rate_reg[i];
                KIND_ANGLE: axis_val[i] = AXIS_W'(angle_sum[i] >>> PI_FRAC);
                default:    axis_val[i] = '0;
            endcase
        end
        temp_val = signed'({1'b0, b_tprod_reg[TPROD_W-1:RECIP_SH]}) - TEMP_OFFSET;
    end

    // output register
    assign m_valid_next = out_ready ? b_valid_reg : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_valid_reg && out_ready) begin
            m_kind_reg <= b_kind_reg;
            m_temp_reg <= temp_val;
            for (int i = 0; i < NUM_AXES; i++) begin
                m_axis_reg[i] <= axis_val[i];
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {3'b000, m_temp_reg, m_axis_reg[2], m_axis_reg[1], m_axis_reg[0]};

`ifndef SYNTHESIS
    // counter never leaves the frame range
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_count_reg <= COUNT_W'(FRAME_LEN - 1))
        else $error("byte counter out of range");

    // a complete frame of known type reaches the product stage
    a_frame_to_b: assert property (@(posedge aclk) disable iff (!aresetn)
        (frame_done && kind_valid) |=> b_valid_reg)
        else $error("complete frame lost");

    // an unknown type leaves nothing behind when the stage drains
    a_unknown_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (frame_done && !kind_valid) |=> !b_valid_reg)
        else $error("unknown frame produced a result");

    // full product stage behind a stalled output holds the input off
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && m_valid_reg && !m_tready) |-> !s_tready)
        else $error("input accepted with pipeline full");

    // reset empties the pipeline and restarts the hunt
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> (byte_count_reg == '0 && !b_valid_reg && !m_valid_reg))
        else $error("reset did not clear control state");
`endif

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the imu serial frame parser. Serial bytes are streamed into
// the slave side with random gaps. A local decoder tracks the frame counter,
// type byte and payload, and scales the four words of each complete frame of
// known type. Results from the master side are checked field by field, in
// order, against the queue of predicted frames.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import imusfp_pkg::*;

    // scaling of a raw word into q16
    localparam longint ACCEL_GAIN    = 32;
    localparam longint RATE_GAIN     = 4000;
    localparam longint TWO_PI_Q44    = 64'h6487ED5110B4;
    localparam int     TWO_PI_FRAC   = 44;
    localparam longint TEMP_BIAS_Q16 = 807731200;
    localparam longint TEMP_DIV      = 340;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_GAP      = 5;

    // one decoded frame as it appears on the master side
    typedef struct {
        frame_kind_t              kind;
        logic signed [AXIS_W-1:0] x;
        logic signed [AXIS_W-1:0] y;
        logic signed [AXIS_W-1:0] z;
        logic signed [TEMP_W-1:0] temp;
    } imu_frame_t;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata  = 8'h00;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic [1:0]         m_tuser;

    // decoder state
    int         rx_count = 0;
    logic [7:0] rx_type;
    logic [7:0] rx_payload [PAYLOAD_LEN];

    imu_frame_t pending_frames [$];
    int         error_count  = 0;
    int         cycle_count  = 0;
    int         src_gap_max  = 0;
    int         sink_gap_max = 0;
    int         sink_hold    = 0;

    imu_serial_frame_parser DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // one axis word scaled to q16, floor for the angle
    function automatic logic signed [AXIS_W-1:0] scale_axis(frame_kind_t kind,
                                                            logic [15:0] raw);
        longint r;
        longint v;
        r = longint'($signed(raw));
        case (kind)
            KIND_ACCEL: v = r * ACCEL_GAIN;
            KIND_RATE:  v = r * RATE_GAIN;
            default:    v = (r * TWO_PI_Q44) >>> TWO_PI_FRAC;
        endcase
        return v[AXIS_W-1:0];
    endfunction

    // temperature word to q16 degrees, division rounded down
    function automatic logic signed [TEMP_W-1:0] scale_temp(logic [15:0] raw);
        longint num;
        longint q;
        num = longint'($signed(raw)) * 65536 + TEMP_BIAS_Q16;
        if (num >= 0)
            q = num / TEMP_DIV;
        else
            q = -((-num + TEMP_DIV - 1) / TEMP_DIV);
        return q[TEMP_W-1:0];
    endfunction

    // advance the frame decoder by one byte; 1 when a frame is produced
    function automatic bit decode_rx_byte(input logic [7:0] b, output imu_frame_t res);
        logic [15:0] w [4];
        bit known;
        known = 1'b0;
        if (rx_count == 0) begin
            if (b == HEADER_BYTE)
                rx_count = 1;
        end else if (rx_count == 1) begin
            rx_type  = b;
            rx_count = 2;
        end else if (rx_count <= FRAME_LEN - 2) begin
            rx_payload[rx_count - 2] = b;
            rx_count++;
        end else begin
            // checksum byte closes the frame without any check
            rx_count = 0;
            known    = 1'b1;
            case (rx_type)
                TYPE_ACCEL: res.kind = KIND_ACCEL;
                TYPE_RATE:  res.kind = KIND_RATE;
                TYPE_ANGLE: res.kind = KIND_ANGLE;
                default:    known = 1'b0;
            endcase
            if (known) begin
                for (int k = 0; k < 4; k++)
                    w[k] = {rx_payload[2*k+1], rx_payload[2*k]};
                res.x    = scale_axis(res.kind, w[0]);
                res.y    = scale_axis(res.kind, w[1]);
                res.z    = scale_axis(res.kind, w[2]);
                res.temp = scale_temp(w[3]);
            end
        end
        return known;
    endfunction

    // check results first, then predict from the accepted byte
    always @(posedge aclk) begin : frame_monitor
        imu_frame_t due;
        imu_frame_t made;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_frames.size() == 0) begin
                    $error("unexpected frame: kind %0d", m_tuser);
                    error_count++;
                end else begin
                    due = pending_frames.pop_front();
                    if (m_tuser !== due.kind) begin
                        $error("frame_kind: expected %0d actual %0d", due.kind, m_tuser);
                        error_count++;
                    end
                    if ($signed(m_tdata[27:0]) !== due.x) begin
                        $error("axis_x: expected %0d actual %0d", due.x,
                               $signed(m_tdata[27:0]));
                        error_count++;
                    end
                    if ($signed(m_tdata[55:28]) !== due.y) begin
                        $error("axis_y: expected %0d actual %0d", due.y,
                               $signed(m_tdata[55:28]));
                        error_count++;
                    end
                    if ($signed(m_tdata[83:56]) !== due.z) begin
                        $error("axis_z: expected %0d actual %0d", due.z,
                               $signed(m_tdata[83:56]));
                        error_count++;
                    end
                    if ($signed(m_tdata[108:84]) !== due.temp) begin
                        $error("temperature: expected %0d actual %0d", due.temp,
                               $signed(m_tdata[108:84]));
                        error_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (decode_rx_byte(s_tdata, made))
                    pending_frames.push_back(made);
            end
        end
    end

    // result side: random ready gaps, plus a long hold when asked
    always begin : result_sink
        int n;
        wait (aresetn);
        if (sink_hold > 0) begin
            n = sink_hold;
            sink_hold = 0;
            repeat (n) begin
                @(negedge aclk);
                m_tready <= 1'b0;
            end
        end
        n = $urandom_range(0, sink_gap_max);
        repeat (n) begin
            @(negedge aclk);
            m_tready <= 1'b0;
        end
        @(negedge aclk);
        m_tready <= 1'b1;
        do @(posedge aclk); while (!m_tvalid && sink_hold == 0);
    end

    // offer one byte after a random gap and wait until it is taken
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_frame(input logic [7:0] ftype, input logic [15:0] w0,
                              input logic [15:0] w1, input logic [15:0] w2,
                              input logic [15:0] w3, input logic [7:0] chk);
        send_byte(HEADER_BYTE);
        send_byte(ftype);
        send_byte(w0[7:0]);
        send_byte(w0[15:8]);
        send_byte(w1[7:0]);
        send_byte(w1[15:8]);
        send_byte(w2[7:0]);
        send_byte(w2[15:8]);
        send_byte(w3[7:0]);
        send_byte(w3[15:8]);
        send_byte(chk);
    endtask

    // raw word biased towards the extremes
    function automatic logic [15:0] pick_raw();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_known_type();
        case ($urandom_range(0, 2))
            0:       return TYPE_ACCEL;
            1:       return TYPE_RATE;
            default: return TYPE_ANGLE;
        endcase
    endfunction

    task automatic send_random_frame(input logic [7:0] ftype);
        send_frame(ftype, pick_raw(), pick_raw(), pick_raw(), pick_raw(),
                   8'($urandom));
    endtask

    // stop offering and let every expected frame come out
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // bytes before a header are dropped
    task automatic test_hunting();
        src_gap_max  = 0;
        sink_gap_max = 0;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hAA);
        send_byte(TYPE_ACCEL);
        send_frame(TYPE_ACCEL, 16'h0000, 16'h0001, 16'hFFFF, 16'h1234, 8'h00);
    endtask

    // each frame type with the word extremes
    task automatic test_frame_kinds();
        src_gap_max  = MAX_GAP;
        sink_gap_max = MAX_GAP;
        send_frame(TYPE_ACCEL, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 8'hFF);
        send_frame(TYPE_RATE, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 8'h01);
        send_frame(TYPE_ANGLE, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001, 8'h80);
        send_frame(TYPE_ANGLE, 16'h0001, 16'h0000, 16'h8001, 16'hFFFF, 8'h7F);
    endtask

    // unknown type bytes give nothing, a following known frame still decodes
    task automatic test_unknown_type();
        src_gap_max  = 2;
        sink_gap_max = 0;
        send_frame(8'h54, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 8'hFF);
        send_frame(HEADER_BYTE, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 8'h00);
        send_frame(TYPE_RATE, 16'hFFFF, 16'h0001, 16'h7FFF, 16'h8000, 8'h55);
    endtask

    // header value inside the payload and as checksum is plain data
    task automatic test_header_in_data();
        src_gap_max  = 1;
        sink_gap_max = 3;
        send_frame(TYPE_ANGLE, 16'h5555, 16'h5555, 16'h0055, 16'h5500, HEADER_BYTE);
        send_frame(TYPE_ACCEL, 16'hAAAA, 16'h5555, 16'hCAFE, 16'h0155, 8'h3C);
    endtask

    // receiver holds off while the sender keeps going
    task automatic test_backpressure();
        src_gap_max  = 0;
        sink_gap_max = 0;
        sink_hold    = 400;
        repeat (10) send_random_frame(pick_known_type());
        sink_gap_max = MAX_GAP;
    endtask

    // sender pauses until all results are out, then carries on
    task automatic test_pause_until_drained();
        src_gap_max  = MAX_GAP;
        sink_gap_max = MAX_GAP;
        repeat (4) send_random_frame(pick_known_type());
        wait_drained();
        repeat (4) send_random_frame(pick_known_type());
        wait_drained();
    endtask

    // mostly good frames, some unknown types, noise and cut-off frames
    task automatic test_random_stream();
        int pick;
        int n;
        logic [7:0] t;
        for (int i = 0; i < 25; i++) begin
            if (i % 10 == 0) begin
                src_gap_max  = ($urandom_range(0, 2) == 0) ? 0 : MAX_GAP;
                sink_gap_max = ($urandom_range(0, 2) == 0) ? 0 : MAX_GAP;
            end
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                send_random_frame(pick_known_type());
            end else if (pick == 7) begin
                do t = 8'($urandom); while (t inside {TYPE_ACCEL, TYPE_RATE, TYPE_ANGLE});
                send_random_frame(t);
            end else if (pick == 8) begin
                n = $urandom_range(1, 5);
                repeat (n) send_byte(8'($urandom));
            end else begin
                // frame cut short, the next one is swallowed as data
                n = $urandom_range(1, 9);
                send_byte(HEADER_BYTE);
                repeat (n) send_byte(8'($urandom));
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_hunting();
        test_frame_kinds();
        test_unknown_type();
        test_header_in_data();
        test_backpressure();
        test_pause_until_drained();
        test_random_stream();
        wait_drained();

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### filelist.f
sv/imusfp_pkg.sv
sv/imu_serial_frame_parser.sv
tb/tb_top.sv
